@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the bucketed key/value table rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i edge outside reset
`define BKVT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// condition that must never be seen outside reset
`define BKVT_ASSERT_NEVER(label, cond) `BKVT_ASSERT(label, !(cond))

`endif

@@ rtl/bkvt_pkg.sv @@
// ----------------------------------------------------------------------------
// bkvt_pkg
// shared types and constants of the bucketed key/value table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bkvt_pkg;

  // table geometry
  localparam int unsigned Buckets   = 256;
  localparam int unsigned Ways      = 4;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValueBits = 32;

  // port field widths
  localparam int unsigned PortKeyBits   = 32;
  localparam int unsigned PortValueBits = 32;
  localparam int unsigned PortCountBits = 11;

  // derived sizes
  localparam int unsigned Slots       = Buckets * Ways;
  localparam int unsigned BucketBits  = $clog2(Buckets);
  localparam int unsigned WayBits     = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned CountBits   = $clog2(Slots + 1);
  localparam int unsigned StKeyBits   = (KeyBits < PortKeyBits) ? KeyBits : PortKeyBits;
  localparam int unsigned StValueBits = (ValueBits < PortValueBits) ? ValueBits : PortValueBits;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  // command codes on the input port
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } bkvt_status_e;

  // action chosen by the front for one transaction
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_ERASE,
    OP_FIND,
    OP_IGNORE
  } bkvt_op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK
  } bkvt_state_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [PortKeyBits-1:0]   key;
    logic [PortValueBits-1:0] value;
  } bkvt_in_t;

  typedef struct packed {
    bkvt_status_e             status;
    logic [PortValueBits-1:0] found_value;
    logic [PortCountBits-1:0] entry_count;
  } bkvt_out_t;

  typedef struct packed {
    bkvt_op_e               op;
    logic [BucketBits-1:0]  bucket;
    logic [StKeyBits-1:0]   key;
    logic [StValueBits-1:0] value;
  } bkvt_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bkvt_qstat_t;

  typedef struct packed {
    logic                   vld;
    logic [StKeyBits-1:0]   key;
    logic [StValueBits-1:0] value;
  } bkvt_slot_t;

  typedef bkvt_slot_t [Ways-1:0] bkvt_row_t;

endpackage

@@ rtl/bkvt_front.sv @@
// ----------------------------------------------------------------------------
// bkvt_front
// accepts transactions, decodes the command and computes the bucket
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkvt_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bkvt_pkg::bkvt_in_t    in_data_i,
  input  bkvt_pkg::bkvt_qstat_t qstat_i,
  input  logic                  init_done_i,
  output logic                  push_o,
  output bkvt_pkg::bkvt_job_t   job_o
);
  import bkvt_pkg::*;

  assign in_ready_o = init_done_i && !qstat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    case (in_data_i.command)
      CMD_INSERT: job_o.op = OP_INSERT;
      CMD_ERASE:  job_o.op = OP_ERASE;
      CMD_FIND:   job_o.op = OP_FIND;
      default:    job_o.op = OP_IGNORE;
    endcase
    job_o.key    = in_data_i.key[StKeyBits-1:0];
    job_o.value  = in_data_i.value[StValueBits-1:0];
    job_o.bucket = in_data_i.key[BucketBits-1:0];
  end

endmodule

@@ rtl/bkvt_queue.sv @@
// ----------------------------------------------------------------------------
// bkvt_queue
// short fifo of decoded jobs between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bkvt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bkvt_pkg::bkvt_job_t   job_i,
  input  logic                  pop_i,
  output bkvt_pkg::bkvt_job_t   job_o,
  output bkvt_pkg::bkvt_qstat_t qstat_o
);
  import bkvt_pkg::*;

  bkvt_job_t           entry_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrBits-1:0] ptr_inc(input logic [QPtrBits-1:0] p);
    logic [QPtrBits-1:0] r;
    if (p == QPtrBits'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign qstat_o.full  = (cnt_q == QCntBits'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign job_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // pop only from a non-empty queue, push only into a non-full one
  `BKVT_ASSERT_NEVER(a_pop_empty, pop_i && (cnt_q == '0))
  `BKVT_ASSERT_NEVER(a_push_full, push_i && !pop_i && (cnt_q == QCntBits'(QueueDepth)))

endmodule

@@ rtl/bkvt_back.sv @@
// ----------------------------------------------------------------------------
// bkvt_back
// bucket row memory, lookup and write back, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bkvt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bkvt_pkg::bkvt_job_t   job_i,
  input  bkvt_pkg::bkvt_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  init_done_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bkvt_pkg::bkvt_out_t   out_data_o
);
  import bkvt_pkg::*;

  bkvt_row_t             mem [Buckets];
  bkvt_row_t             rd_q;

  bkvt_state_e           state_q, state_d;
  logic [BucketBits-1:0] clr_q, clr_d;
  bkvt_job_t             op_q;
  logic [CountBits-1:0]  live_q, live_d, live_calc;
  logic                  out_valid_q, out_valid_d;
  bkvt_out_t             out_q;

  logic                  mem_re, mem_we;
  logic [BucketBits-1:0] mem_waddr;
  bkvt_row_t             mem_wdata;
  logic                  load;

  // lookup results
  logic [Ways-1:0]       match_v, free_v;
  logic                  hit, has_free;
  logic [WayBits-1:0]    hit_way, free_way;
  bkvt_row_t             new_row;
  bkvt_status_e          status;
  logic [StValueBits-1:0] found;
  logic                  changed;

  // per-way compare and lowest-way pick
  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < Ways; w++) begin
      match_v[w] = rd_q[w].vld && (rd_q[w].key == op_q.key);
      free_v[w]  = !rd_q[w].vld;
    end
    for (int w = 0; w < Ways; w++) begin
      if (!hit && match_v[w]) begin
        hit     = 1'b1;
        hit_way = WayBits'(w);
      end
      if (!has_free && free_v[w]) begin
        has_free = 1'b1;
        free_way = WayBits'(w);
      end
    end
  end

  // row update and result
  always_comb begin
    new_row   = rd_q;
    status    = ST_NOT_FOUND;
    found     = '0;
    live_calc = live_q;
    changed   = 1'b0;
    case (op_q.op)
      OP_INSERT: begin
        status = ST_FULL;
        if (has_free) begin
          new_row[free_way].vld   = 1'b1;
          new_row[free_way].key   = op_q.key;
          new_row[free_way].value = op_q.value;
          status    = ST_OK;
          live_calc = live_q + 1'b1;
          changed   = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          new_row[hit_way].vld = 1'b0;
          status  = ST_OK;
          changed = 1'b1;
          if (live_q != '0) begin
            live_calc = live_q - 1'b1;
          end
        end
      end
      OP_FIND: begin
        if (hit) begin
          found  = rd_q[hit_way].value;
          status = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: clear pass, row read, compare and write back
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pop_o       = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = op_q.bucket;
    mem_wdata   = new_row;
    load        = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == BucketBits'(Buckets - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          mem_re  = 1'b1;
          state_d = BK_LOOK;
        end
      end
      BK_LOOK: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          mem_we  = changed;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    live_d      = load ? live_calc : live_q;
    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= job_i;
    end
    if (load) begin
      out_q.status      <= status;
      out_q.found_value <= PortValueBits'(found);
      out_q.entry_count <= PortCountBits'(live_calc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[job_i.bucket];
    end
  end

  assign init_done_o = (state_q != BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // count never exceeds capacity, and nothing moves during the clear pass
  `BKVT_ASSERT(a_live_cap, live_q <= CountBits'(Slots))
  `BKVT_ASSERT_NEVER(a_clear_quiet, (state_q == BK_CLEAR) && (pop_o || out_valid_q))
  // a finished lookup always leaves a result behind
  `BKVT_ASSERT(a_load_result, load |=> out_valid_q)

endmodule

@@ rtl/bucketed_key_value_table_unit.sv @@
// ----------------------------------------------------------------------------
// bucketed_key_value_table_unit
// key/value table with power-of-two buckets of fixed ways per bucket
// ----------------------------------------------------------------------------
// Each transaction is an insert, erase or find on a table of 256 buckets of
// 4 ways; the bucket is the low 8 bits of the key. Insert takes the lowest
// free way without checking for duplicates (status bucket full when none is
// free), erase clears the lowest matching way, find returns the value of the
// lowest matching way; every result carries the live entry count. After
// reset the table runs a clearing pass, one bucket row per cycle, during
// which in_ready_o stays low. Then the back end reads the bucket row of
// each transaction from the row memory, compares all ways and writes the
// row back if it changed, and only then takes the next transaction; the
// compare step waits while the previous result is held. A 2-entry queue
// sits between the decoding front end and the back end, and results wait
// in an output register, so up to three more transactions are taken in
// while a result is held by out_ready_i; a result passes through the queue,
// the row read register and the output register before it is presented.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bucketed_key_value_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request transactions
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bkvt_pkg::bkvt_in_t  in_data_i,
  // result transactions
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bkvt_pkg::bkvt_out_t out_data_o
);
  import bkvt_pkg::*;

  // front to queue
  logic        push;
  bkvt_job_t   front_job;
  // queue to back
  bkvt_job_t   head_job;
  bkvt_qstat_t qstat;
  logic        pop;
  // back is done with the clearing pass
  logic        init_done;

  // decode command, pick bucket, gate acceptance
  bkvt_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .qstat_i     (qstat),
    .init_done_i (init_done),
    .push_o      (push),
    .job_o       (front_job)
  );

  // decouples acceptance from the row read/write sequence
  bkvt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  // row memory, way compare, write back and result register
  bkvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
